@@ hw/rtl/wsc_pkg.sv @@
// Shared widths, configuration codes, reset values and constant tables
// for the wind spatial coherence pipeline. No dependencies.
package wsc_pkg;

  // Input and configuration field widths
  localparam int COORD_W   = 24;
  localparam int SPEED_W   = 16;
  localparam int FREQ_W    = 16;
  localparam int DECAY_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int COH_W     = 16;

  // Distance path
  localparam int DIFF_W = COORD_W + 1;
  localparam int WGT_W  = DECAY_W + DIFF_W;
  localparam int WLO_W  = 19;
  localparam int WHI_W  = WGT_W - WLO_W;
  localparam int SQ_W   = 2 * WGT_W;
  localparam int RAD_W  = SQ_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SPD_W  = SPEED_W + 1;

  // Exponent argument path
  localparam int FD_W        = FREQ_W + ROOT_W;
  localparam int NUM_W       = FD_W + 7;
  localparam int DEN_W       = 26;
  localparam int FRAC_W      = 16;
  localparam int INT_W       = 4;
  localparam int QUO_W       = INT_W + FRAC_W;
  localparam int LIM_W       = DEN_W + QUO_W;
  localparam int SPEED_SCALE = 314;
  localparam int LIMIT_INT   = 12;

  // Exponential path
  localparam int TERMS     = 12;
  localparam int TERM_W    = 33;
  localparam int SUM_W     = 34;
  localparam int PROD_W    = TERM_W + FRAC_W;
  localparam int X_W       = 32;
  localparam int RECIP_W   = 33;
  localparam int MQ_W      = 65;
  localparam int EXP_TAB_N = 2 ** INT_W;
  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

  // Register reset values
  localparam logic [DECAY_W-1:0] DECAY_X_RST = DECAY_W'(160);
  localparam logic [DECAY_W-1:0] DECAY_Y_RST = DECAY_W'(112);
  localparam logic [DECAY_W-1:0] DECAY_Z_RST = DECAY_W'(96);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY_X = 2'd0,
    REG_DECAY_Y = 2'd1,
    REG_DECAY_Z = 2'd2
  } cfg_reg_t;

  // Sideband that travels with each beat through the pipeline
  typedef struct packed {
    logic [SPD_W-1:0]  spd;
    logic [FREQ_W-1:0] freq;
    logic              speed_zero;
    logic              q_zero;
    logic              big;
  } ctx_t;

  // exp(-n) in Q.32 for each integer part, each product rounded half up
  function automatic logic [EXP_TAB_N-1:0][TERM_W-1:0] exp_int_table();
    logic [EXP_TAB_N-1:0][TERM_W-1:0] tab;
    logic [63:0] p;
    p = 64'd1 << 32;
    for (int i = 0; i < EXP_TAB_N; i++) begin
      tab[i] = TERM_W'(p);
      p = (p * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

endpackage

@@ hw/rtl/wsc_if.sv @@
// Channel interfaces for the coherence block: item, result and config.
// Depends on wsc_pkg for field widths.
interface wsc_item_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wsc_pkg::COORD_W-1:0]   first_x;
  logic signed [wsc_pkg::COORD_W-1:0]   first_y;
  logic signed [wsc_pkg::COORD_W-1:0]   first_z;
  logic signed [wsc_pkg::COORD_W-1:0]   second_x;
  logic signed [wsc_pkg::COORD_W-1:0]   second_y;
  logic signed [wsc_pkg::COORD_W-1:0]   second_z;
  logic        [wsc_pkg::SPEED_W-1:0]   first_speed;
  logic        [wsc_pkg::SPEED_W-1:0]   second_speed;
  logic        [wsc_pkg::FREQ_W-1:0]    frequency;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  first_speed, second_speed, frequency, input ready);
  modport sink   (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  first_speed, second_speed, frequency, output ready);
endinterface

interface wsc_result_if;
  logic                         valid;
  logic                         ready;
  logic [wsc_pkg::COH_W-1:0]    coherence;
  logic                         speed_zero;

  modport source (output valid, coherence, speed_zero, input ready);
  modport sink   (input valid, coherence, speed_zero, output ready);
endinterface

interface wsc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wsc_pkg::CFG_IDX_W-1:0]   index;
  logic [wsc_pkg::DECAY_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/wsc_dist.sv @@
// Weighted squared distance: coordinate differences, decay weighting,
// split squares and the three-axis sum over five stages. Uses wsc_pkg.
module wsc_dist (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [wsc_pkg::COORD_W-1:0]  first [3],
  input  logic signed [wsc_pkg::COORD_W-1:0]  second [3],
  input  logic        [wsc_pkg::SPEED_W-1:0]  first_speed,
  input  logic        [wsc_pkg::SPEED_W-1:0]  second_speed,
  input  logic        [wsc_pkg::FREQ_W-1:0]   frequency,
  input  logic        [wsc_pkg::DECAY_W-1:0]  decay [3],
  output logic                                out_vld,
  output logic        [wsc_pkg::RAD_W-1:0]    q,
  output wsc_pkg::ctx_t                       out_ctx
);
  import wsc_pkg::*;

  logic signed [DIFF_W-1:0] dab [3];
  logic signed [DIFF_W-1:0] dba [3];
  logic [SPD_W-1:0]         spd_sum;

  logic [DIFF_W-1:0]  mag [3];
  logic [WGT_W-1:0]   wgt [3];
  logic [2*WHI_W-1:0] hh [3];
  logic [WGT_W-1:0]   hl [3];
  logic [2*WLO_W-1:0] ll [3];
  logic [SQ_W-1:0]    sq [3];
  logic               v1, v2, v3, v4, v5;
  ctx_t               c1, c2, c3, c4, c5;

  // Both difference orders in parallel, pick the non-negative one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dab[i] = DIFF_W'(first[i]) - DIFF_W'(second[i]);
      dba[i] = DIFF_W'(second[i]) - DIFF_W'(first[i]);
    end
    spd_sum = SPD_W'(first_speed) + SPD_W'(second_speed);
  end

  // Stage 1: magnitudes and speed sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= dab[i][DIFF_W-1] ? unsigned'(dba[i]) : unsigned'(dab[i]);
      end
      c1.spd        <= spd_sum;
      c1.freq       <= frequency;
      c1.speed_zero <= (spd_sum == '0);
      c1.q_zero     <= 1'b0;
      c1.big        <= 1'b0;
    end
  end

  // Stage 2: weight by the decay coefficients
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        wgt[i] <= WGT_W'(decay[i]) * WGT_W'(mag[i]);
      end
      c2 <= c1;
    end
  end

  // Stage 3: partial products of each square
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh[i] <= (2*WHI_W)'(wgt[i][WGT_W-1:WLO_W]) * (2*WHI_W)'(wgt[i][WGT_W-1:WLO_W]);
        hl[i] <= WGT_W'(wgt[i][WGT_W-1:WLO_W]) * WGT_W'(wgt[i][WLO_W-1:0]);
        ll[i] <= (2*WLO_W)'(wgt[i][WLO_W-1:0]) * (2*WLO_W)'(wgt[i][WLO_W-1:0]);
      end
      c3 <= '{spd: c2.spd, freq: c2.freq, speed_zero: c2.speed_zero,
              q_zero: (wgt[0] == '0) && (wgt[1] == '0) && (wgt[2] == '0),
              big: c2.big};
    end
  end

  // Stage 4: assemble each square
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= (SQ_W'(hh[i]) << (2*WLO_W)) + (SQ_W'(hl[i]) << (WLO_W+1)) + SQ_W'(ll[i]);
      end
      c4 <= c3;
    end
  end

  // Stage 5: sum over the axes
  always_ff @(posedge clk) begin
    if (en) begin
      q  <= RAD_W'(sq[0]) + RAD_W'(sq[1]) + RAD_W'(sq[2]);
      c5 <= c4;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  assign out_vld = v5;
  assign out_ctx = c5;

endmodule

@@ hw/rtl/wsc_sqrt.sv @@
// Integer square root, one result bit per pipeline stage (digit by digit).
// Uses wsc_pkg for widths and the sideband type.
module wsc_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [wsc_pkg::RAD_W-1:0]       q,
  input  wsc_pkg::ctx_t                   in_ctx,
  output logic                            out_vld,
  output logic [wsc_pkg::ROOT_W-1:0]      root,
  output wsc_pkg::ctx_t                   out_ctx
);
  import wsc_pkg::*;

  logic [RAD_W-1:0]  rad  [ROOT_W+1];
  logic [REM_W-1:0]  rem  [ROOT_W+1];
  logic [ROOT_W-1:0] rt   [ROOT_W+1];
  ctx_t              ctx  [ROOT_W+1];
  logic              vld  [ROOT_W+1];

  assign rad[0] = q;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign ctx[0] = in_ctx;
  assign vld[0] = in_vld;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             fit;

    // Bring down the next two radicand bits and try the next root bit
    always_comb begin
      cur   = {rem[g][REM_W-3:0], rad[g][RAD_W-1 -: 2]};
      trial = (REM_W'(rt[g]) << 2) | REM_W'(1);
      fit   = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= fit ? cur - trial : cur;
        rt[g+1]  <= {rt[g][ROOT_W-2:0], fit};
        rad[g+1] <= rad[g] << 2;
        ctx[g+1] <= ctx[g];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end
  end

  assign out_vld = vld[ROOT_W];
  assign root    = rt[ROOT_W];
  assign out_ctx = ctx[ROOT_W];

endmodule

@@ hw/rtl/wsc_div.sv @@
// Exponent argument: f*D*100 divided by 314*(U1+U2) as a Q.16 quotient,
// restoring division one quotient bit per stage. Uses wsc_pkg.
module wsc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [wsc_pkg::ROOT_W-1:0]      root,
  input  wsc_pkg::ctx_t                   in_ctx,
  output logic                            out_vld,
  output logic [wsc_pkg::INT_W-1:0]       n_int,
  output logic [wsc_pkg::FRAC_W-1:0]      af,
  output wsc_pkg::ctx_t                   out_ctx
);
  import wsc_pkg::*;

  localparam int LO_W = 32;
  localparam int HI_W = ROOT_W - LO_W;

  logic [FREQ_W+LO_W-1:0] fr_lo;
  logic [FREQ_W+HI_W-1:0] fr_hi;
  logic [DEN_W-1:0]       den1, den2;
  logic [FD_W-1:0]        fd;
  logic [LIM_W-1:0]       lim2, lim3;
  logic                   v1, v2;
  ctx_t                   c1, c2;

  logic [NUM_W-1:0] rem [QUO_W+1];
  logic [QUO_W-1:0] quo [QUO_W+1];
  logic [DEN_W-1:0] den [QUO_W+1];
  ctx_t             ctx [QUO_W+1];
  logic             vld [QUO_W+1];

  // Stage 1: split product of frequency and root, scaled speed sum
  always_ff @(posedge clk) begin
    if (en) begin
      fr_lo <= (FREQ_W+LO_W)'(in_ctx.freq) * (FREQ_W+LO_W)'(root[LO_W-1:0]);
      fr_hi <= (FREQ_W+HI_W)'(in_ctx.freq) * (FREQ_W+HI_W)'(root[ROOT_W-1:LO_W]);
      den1  <= DEN_W'(in_ctx.spd) * DEN_W'(SPEED_SCALE);
      c1    <= in_ctx;
    end
  end

  // Stage 2: join the partial products, limit for the zero-coherence case
  always_ff @(posedge clk) begin
    if (en) begin
      fd   <= (FD_W'(fr_hi) << LO_W) + FD_W'(fr_lo);
      den2 <= den1;
      lim2 <= (LIM_W'(den1) << (FRAC_W+3)) + (LIM_W'(den1) << (FRAC_W+2));
      c2   <= c1;
    end
  end

  // Stage 3: times 100 as shifts and adds
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (NUM_W'(fd) << 6) + (NUM_W'(fd) << 5) + (NUM_W'(fd) << 2);
      quo[0] <= '0;
      den[0] <= den2;
      lim3   <= lim2;
      ctx[0] <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      vld[0] <= 1'b0;
    end else if (en) begin
      v1     <= in_vld;
      v2     <= v1;
      vld[0] <= v2;
    end
  end

  // Restoring division, most significant quotient bit first
  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    localparam int BIT = QUO_W - 1 - g;
    logic [NUM_W-1:0] sub;
    logic             fit;
    ctx_t             ctx_next;

    always_comb begin
      sub      = NUM_W'(den[g]) << BIT;
      fit      = (rem[g] >= sub);
      ctx_next = ctx[g];
      if (g == 0) begin
        ctx_next.big = (rem[g] >= NUM_W'(lim3));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= fit ? rem[g] - sub : rem[g];
        quo[g+1] <= {quo[g][QUO_W-2:0], fit};
        den[g+1] <= den[g];
        ctx[g+1] <= ctx_next;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end
  end

  assign out_vld = vld[QUO_W];
  assign n_int   = quo[QUO_W][QUO_W-1:FRAC_W];
  assign af      = quo[QUO_W][FRAC_W-1:0];
  assign out_ctx = ctx[QUO_W];

endmodule

@@ hw/rtl/wsc_exp.sv @@
// exp(-a): table for the integer part, twelve-term series for the fraction,
// three stages per term with reciprocal division, final product. Uses wsc_pkg.
module wsc_exp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [wsc_pkg::INT_W-1:0]       n_int,
  input  logic [wsc_pkg::FRAC_W-1:0]      af,
  input  wsc_pkg::ctx_t                   in_ctx,
  output logic                            out_vld,
  output logic [wsc_pkg::COH_W-1:0]       coherence,
  output logic                            speed_zero
);
  import wsc_pkg::*;

  localparam logic [EXP_TAB_N-1:0][TERM_W-1:0] EXP_INT = exp_int_table();
  localparam logic [TERM_W-1:0] ONE_Q32  = TERM_W'(64'd1 << 32);
  localparam int                RND_BIT  = 45;
  localparam int                OUT_SH   = 46;
  localparam int                V_W      = MQ_W - OUT_SH;
  localparam logic [V_W-1:0]    SAT_MAX  = V_W'(2 ** COH_W - 1);

  // Add an even term, subtract an odd one and floor at zero
  function automatic logic [SUM_W-1:0] s_next(input logic [SUM_W-1:0]  s,
                                               input logic [TERM_W-1:0] term,
                                               input logic              odd);
    logic [SUM_W-1:0] t;
    t = SUM_W'(term);
    if (odd) begin
      return (t > s) ? '0 : s - t;
    end
    return s + t;
  endfunction

  logic [TERM_W-1:0] bt_term [TERMS+1];
  logic [SUM_W-1:0]  bt_s    [TERMS+1];
  logic [TERM_W-1:0] bt_p    [TERMS+1];
  logic [FRAC_W-1:0] bt_af   [TERMS+1];
  ctx_t              bt_ctx  [TERMS+1];
  logic              bt_vld  [TERMS+1];

  logic [SUM_W-1:0]  f1_s;
  logic [TERM_W-1:0] f1_p;
  logic [MQ_W-1:0]   f2_mul;
  logic [MQ_W-1:0]   rnd;
  logic [V_W-1:0]    val;
  logic              f1_v, f2_v, f3_v;
  ctx_t              f1_c, f2_c;

  // Entry stage: integer part from the table, series starts at one
  always_ff @(posedge clk) begin
    if (en) begin
      bt_p[0]    <= EXP_INT[n_int];
      bt_term[0] <= ONE_Q32;
      bt_s[0]    <= SUM_W'(ONE_Q32);
      bt_af[0]   <= af;
      bt_ctx[0]  <= in_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bt_vld[0] <= 1'b0;
    end else if (en) begin
      bt_vld[0] <= in_vld;
    end
  end

  for (genvar t = 0; t < TERMS; t++) begin : g_term
    localparam int unsigned          K     = t + 1;
    localparam logic [RECIP_W-1:0]   RECIP = RECIP_W'((64'd1 << 32) / K);

    logic [PROD_W-1:0] a_prod;
    logic [SUM_W-1:0]  a_s, b_s;
    logic [TERM_W-1:0] a_p, b_p;
    logic [FRAC_W-1:0] a_af, b_af;
    ctx_t              a_c, b_c;
    logic              a_v, b_v;
    logic [X_W-1:0]    b_x;
    logic [MQ_W-1:0]   b_mq;
    logic [X_W-1:0]    qe;
    logic [X_W-1:0]    rr;

    // Stage a: multiply by the fraction, fold the previous term into the sum
    always_ff @(posedge clk) begin
      if (en) begin
        a_prod <= PROD_W'(bt_term[t]) * PROD_W'(bt_af[t]);
        a_s    <= (t == 0) ? bt_s[t] : s_next(bt_s[t], bt_term[t], (t % 2) == 1);
        a_p    <= bt_p[t];
        a_af   <= bt_af[t];
        a_c    <= bt_ctx[t];
      end
    end

    // Stage b: reciprocal product for the division by k
    always_ff @(posedge clk) begin
      if (en) begin
        b_x  <= a_prod[X_W+FRAC_W-1:FRAC_W];
        b_mq <= MQ_W'(a_prod[X_W+FRAC_W-1:FRAC_W]) * MQ_W'(RECIP);
        b_s  <= a_s;
        b_p  <= a_p;
        b_af <= a_af;
        b_c  <= a_c;
      end
    end

    // Stage c: correct the estimate by at most one
    always_comb begin
      qe = b_mq[X_W+31:32];
      rr = b_x - X_W'(qe * X_W'(K));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bt_term[t+1] <= (rr >= X_W'(K)) ? TERM_W'(qe) + TERM_W'(1) : TERM_W'(qe);
        bt_s[t+1]    <= b_s;
        bt_p[t+1]    <= b_p;
        bt_af[t+1]   <= b_af;
        bt_ctx[t+1]  <= b_c;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v         <= 1'b0;
        b_v         <= 1'b0;
        bt_vld[t+1] <= 1'b0;
      end else if (en) begin
        a_v         <= bt_vld[t];
        b_v         <= a_v;
        bt_vld[t+1] <= b_v;
      end
    end
  end

  // Final stages: last term, product of the two factors, round and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      f1_s   <= s_next(bt_s[TERMS], bt_term[TERMS], (TERMS % 2) == 1);
      f1_p   <= bt_p[TERMS];
      f1_c   <= bt_ctx[TERMS];
      f2_mul <= MQ_W'(f1_p >> 1) * MQ_W'(f1_s >> 1);
      f2_c   <= f1_c;
    end
  end

  always_comb begin
    rnd = f2_mul + (MQ_W'(1) << RND_BIT);
    val = rnd[MQ_W-1:OUT_SH];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      speed_zero <= f2_c.speed_zero;
      if (f2_c.speed_zero) begin
        coherence <= f2_c.q_zero ? '1 : '0;
      end else if (f2_c.big) begin
        coherence <= '0;
      end else begin
        coherence <= (val > SAT_MAX) ? '1 : COH_W'(val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
    end else if (en) begin
      f1_v <= bt_vld[TERMS];
      f2_v <= f1_v;
      f3_v <= f2_v;
    end
  end

  assign out_vld = f3_v;

endmodule

@@ hw/rtl/wind_spatial_coherence.sv @@
// Throughput: one beat per cycle; the pipeline stalls only when the skid stage
// behind the output register is full, set by the result channel's ready.
// Reset: synchronous, active high; clears valid bits and the skid stage and
// loads the decay registers with 10.0, 7.0 and 6.0. Config is always ready.
module wind_spatial_coherence (
  input  logic              clk,
  input  logic              rst,
  wsc_item_if.sink          item,
  wsc_result_if.source      result,
  wsc_cfg_if.sink           cfg
);
  import wsc_pkg::*;

  logic [DECAY_W-1:0] decay [3];
  logic signed [COORD_W-1:0] first [3];
  logic signed [COORD_W-1:0] second [3];

  logic en;
  logic d_vld, s_vld, q_vld, e_vld;
  logic [RAD_W-1:0]  q;
  logic [ROOT_W-1:0] root;
  logic [INT_W-1:0]  n_int;
  logic [FRAC_W-1:0] af;
  ctx_t              d_ctx, s_ctx, q_ctx;
  logic [COH_W-1:0]  e_coh;
  logic              e_sz;

  logic              out_valid;
  logic [COH_W-1:0]  out_coh;
  logic              out_sz;
  logic              skid_valid;
  logic [COH_W-1:0]  skid_coh;
  logic              skid_sz;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay[0] <= DECAY_X_RST;
      decay[1] <= DECAY_Y_RST;
      decay[2] <= DECAY_Z_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_DECAY_X: decay[0] <= cfg.data;
        REG_DECAY_Y: decay[1] <= cfg.data;
        REG_DECAY_Z: decay[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  // Advance the pipeline while the skid stage is empty
  assign en         = !skid_valid;
  assign item.ready = en;

  assign first[0]  = item.first_x;
  assign first[1]  = item.first_y;
  assign first[2]  = item.first_z;
  assign second[0] = item.second_x;
  assign second[1] = item.second_y;
  assign second[2] = item.second_z;

  wsc_dist u_dist (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_vld       (item.valid),
    .first        (first),
    .second       (second),
    .first_speed  (item.first_speed),
    .second_speed (item.second_speed),
    .frequency    (item.frequency),
    .decay        (decay),
    .out_vld      (d_vld),
    .q            (q),
    .out_ctx      (d_ctx)
  );

  wsc_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (d_vld),
    .q       (q),
    .in_ctx  (d_ctx),
    .out_vld (s_vld),
    .root    (root),
    .out_ctx (s_ctx)
  );

  wsc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s_vld),
    .root    (root),
    .in_ctx  (s_ctx),
    .out_vld (q_vld),
    .n_int   (n_int),
    .af      (af),
    .out_ctx (q_ctx)
  );

  wsc_exp u_exp (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_vld     (q_vld),
    .n_int      (n_int),
    .af         (af),
    .in_ctx     (q_ctx),
    .out_vld    (e_vld),
    .coherence  (e_coh),
    .speed_zero (e_sz)
  );

  // Output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (result.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= e_vld;
      end
    end else if (en && e_vld) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (result.ready || !out_valid) begin
      if (skid_valid) begin
        out_coh <= skid_coh;
        out_sz  <= skid_sz;
      end else begin
        out_coh <= e_coh;
        out_sz  <= e_sz;
      end
    end else if (en && e_vld) begin
      skid_coh <= e_coh;
      skid_sz  <= e_sz;
    end
  end

  assign result.valid      = out_valid;
  assign result.coherence  = out_coh;
  assign result.speed_zero = out_sz;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a beat while the output register is empty");

  a_skid_stalls: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !item.ready)
    else $error("item channel ready while the skid stage is full");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !result.ready))
    else $error("skid stage filled without a stalled output");

  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.speed_zero |->
      (result.coherence == '1 || result.coherence == '0))
    else $error("zero speed sum with a coherence other than 0 or full scale");
`endif

endmodule

@@ dv/wsc_coherence_checker.sv @@
// Scoreboard for the wind spatial coherence block: follows the config writes,
// predicts each coherence beat and compares it. Depends on wsc_pkg and wsc_if.
module wsc_coherence_checker (
  input  logic  clk,
  input  logic  rst,
  wsc_item_if   item,
  wsc_result_if result,
  wsc_cfg_if    cfg,
  output int    errors,
  output int    pending,
  output int    checked,
  output int    zero_speed_seen
);
  import wsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COH_W-1:0] coherence;
    logic             speed_zero;
  } coh_beat_t;

  localparam logic [63:0] ONE_Q32 = 64'd1 << 32;

  logic [DECAY_W-1:0] decay_x, decay_y, decay_z;
  coh_beat_t          expected_beats[$];

  // Weighted absolute separation along one axis, units of 1/4096 m
  function automatic logic [63:0] axis_weight(logic [DECAY_W-1:0] c,
                                              logic signed [COORD_W-1:0] p,
                                              logic signed [COORD_W-1:0] q);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        m;
    d = p - q;
    m = d < 0 ? -d : d;
    return 64'(c) * 64'(m);
  endfunction

  // exp(-n - af/65536) in Q0.16, saturated
  function automatic logic [63:0] decay_factor(logic [63:0] n, logic [63:0] af);
    logic [63:0] p, s, term, v;
    p = ONE_Q32;
    s = ONE_Q32;
    term = ONE_Q32;
    for (int k = 0; k < n; k++) p = (p * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
    for (int k = 1; k <= TERMS; k++) begin
      term = ((term * af) >> 16) / k;
      if (k % 2 == 1) s = term > s ? 64'd0 : s - term;
      else s = s + term;
    end
    v = ((p >> 1) * (s >> 1) + (64'd1 << 45)) >> 46;
    return v > 64'd65535 ? 64'd65535 : v;
  endfunction

  // Expected coherence beat for the item on the channel now
  function automatic coh_beat_t predict_coherence();
    logic [63:0]  wx, wy, wz, root, cand, num, den, n, af, spd;
    logic [127:0] sq_sum;
    coh_beat_t    r;
    wx = axis_weight(decay_x, item.first_x, item.second_x);
    wy = axis_weight(decay_y, item.first_y, item.second_y);
    wz = axis_weight(decay_z, item.first_z, item.second_z);
    sq_sum = 128'(wx) * 128'(wx) + 128'(wy) * 128'(wy) + 128'(wz) * 128'(wz);
    spd = 64'(item.first_speed) + 64'(item.second_speed);
    if (spd == 0) begin
      r.coherence = sq_sum == 0 ? 16'hFFFF : 16'h0000;
      r.speed_zero = 1'b1;
      return r;
    end
    root = 0;
    for (int b = 37; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (128'(cand) * 128'(cand) <= sq_sum) root = cand;
    end
    num = 64'(item.frequency) * root * 64'd100;
    den = 64'd65536 * 64'(SPEED_SCALE) * spd;
    n = num / den;
    r.speed_zero = 1'b0;
    if (n >= LIMIT_INT) begin
      r.coherence = '0;
    end else begin
      af = ((num % den) << 16) / den;
      r.coherence = COH_W'(decay_factor(n, af));
    end
    return r;
  endfunction

  // Track registers, queue predictions, compare result beats
  always @(posedge clk) begin
    coh_beat_t want;
    int        err_now;
    err_now = 0;
    if (rst) begin
      decay_x <= DECAY_X_RST;
      decay_y <= DECAY_Y_RST;
      decay_z <= DECAY_Z_RST;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_beats.size() == 0) begin
          $error("coherence beat with nothing expected: coherence=%0d speed_zero=%0b",
                 result.coherence, result.speed_zero);
          err_now = err_now + 1;
        end else begin
          want = expected_beats.pop_front();
          checked <= checked + 1;
          if (want.speed_zero) zero_speed_seen <= zero_speed_seen + 1;
          if (want.coherence !== result.coherence) begin
            $error("coherence: expected %0d, actual %0d", want.coherence, result.coherence);
            err_now = err_now + 1;
          end
          if (want.speed_zero !== result.speed_zero) begin
            $error("speed_zero: expected %0b, actual %0b", want.speed_zero,
                   result.speed_zero);
            err_now = err_now + 1;
          end
        end
      end
      if (err_now != 0) errors <= errors + err_now;
      if (item.valid && item.ready) expected_beats.push_back(predict_coherence());
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_DECAY_X: decay_x <= cfg.data;
          REG_DECAY_Y: decay_y <= cfg.data;
          REG_DECAY_Z: decay_z <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  // Publish the backlog after the queue has settled for this edge
  always @(negedge clk) pending <= expected_beats.size();

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
    zero_speed_seen = 0;
  end
endmodule

@@ dv/wind_spatial_coherence_tb.sv @@
// Top of the coherence testbench: clock, reset, item/config stimulus, result
// back-pressure and verdict. Depends on wsc_pkg, wsc_if and the checker.
module wind_spatial_coherence_tb;
  import wsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;
  localparam int PHASE_ITEMS = 135;

  typedef struct {
    logic signed [COORD_W-1:0] fx, fy, fz, sx, sy, sz;
    logic [SPEED_W-1:0]        u1, u2;
    logic [FREQ_W-1:0]         f;
  } pair_t;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   long_hold_req;
  int   cycles;
  int   errors, pending, checked, zero_speed_seen;

  wsc_item_if   item();
  wsc_result_if result();
  wsc_cfg_if    cfg();

  wind_spatial_coherence dut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source), .cfg(cfg.sink)
  );

  wsc_coherence_checker checker_i (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg(cfg),
    .errors(errors), .pending(pending), .checked(checked),
    .zero_speed_seen(zero_speed_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result back-pressure: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    int hold_left;
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result.ready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req <= 0;
      hold_left = 400;
      result.ready <= 1'b0;
    end else begin
      result.ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // Drive one pair, idling first at the current rate; valid stays high after
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid <= 1'b1;
    item.first_x <= p.fx;
    item.first_y <= p.fy;
    item.first_z <= p.fz;
    item.second_x <= p.sx;
    item.second_y <= p.sy;
    item.second_z <= p.sz;
    item.first_speed <= p.u1;
    item.second_speed <= p.u2;
    item.frequency <= p.f;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
  endtask

  // Hold the item channel until every coherence beat is back
  task automatic drain();
    item.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One register beat, then one idle cycle on the config channel
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DECAY_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_decays(logic [DECAY_W-1:0] x, logic [DECAY_W-1:0] y,
                              logic [DECAY_W-1:0] z);
    drain();
    write_reg(REG_DECAY_X, x);
    write_reg(REG_DECAY_Y, y);
    write_reg(REG_DECAY_Z, z);
  endtask

  function automatic pair_t make_pair(logic signed [COORD_W-1:0] f0,
                                      logic signed [COORD_W-1:0] s0,
                                      logic [SPEED_W-1:0] u1, logic [SPEED_W-1:0] u2,
                                      logic [FREQ_W-1:0] f);
    pair_t p;
    p.fx = f0; p.fy = f0; p.fz = f0;
    p.sx = s0; p.sy = s0; p.sz = s0;
    p.u1 = u1; p.u2 = u2; p.f = f;
    return p;
  endfunction

  // Random value spread over magnitudes so small and large both occur
  function automatic logic [31:0] spread(int w);
    return $urandom() >> (32 - $urandom_range(w));
  endfunction

  // Mostly near pairs that give mid-range coherence; some wide and degenerate
  function automatic pair_t random_pair();
    pair_t p;
    int    mode;
    mode = $urandom_range(99);
    p.fx = COORD_W'($urandom()); p.fy = COORD_W'($urandom()); p.fz = COORD_W'($urandom());
    if (mode < 65) begin
      p.sx = p.fx + $signed(COORD_W'(spread(13))) - $signed(COORD_W'(spread(13)));
      p.sy = p.fy + $signed(COORD_W'(spread(13))) - $signed(COORD_W'(spread(13)));
      p.sz = p.fz + $signed(COORD_W'(spread(13))) - $signed(COORD_W'(spread(13)));
    end else begin
      p.sx = COORD_W'($urandom()); p.sy = COORD_W'($urandom());
      p.sz = COORD_W'($urandom());
    end
    p.u1 = SPEED_W'(spread(SPEED_W));
    p.u2 = SPEED_W'(spread(SPEED_W));
    p.f = FREQ_W'(spread(FREQ_W));
    if (mode >= 95) begin
      p.u1 = '0;
      p.u2 = '0;
      if (mode >= 97) begin
        p.sx = p.fx; p.sy = p.fy; p.sz = p.fz;
      end
    end
    return p;
  endfunction

  initial begin
    pair_t p;
    cycles = 0;
    long_hold_req = 0;
    send_idle_pct = 10;
    recv_idle_pct = 67;
    rst = 1'b1;
    item.valid = 1'b0;
    item.first_x = '0; item.first_y = '0; item.first_z = '0;
    item.second_x = '0; item.second_y = '0; item.second_z = '0;
    item.first_speed = '0; item.second_speed = '0; item.frequency = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_DECAY_X;
    cfg.data = '0;
    result.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners at reset coefficients
    send_pair(make_pair(24'sh7FFFFF, -24'sh800000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pair(make_pair(24'sh7FFFFF, -24'sh800000, 16'hFFFF, 16'hFFFF, 16'd1));
    send_pair(make_pair(24'sh123456, 24'sh123456, 16'd500, 16'd700, 16'hFFFF));
    send_pair(make_pair(24'sh000100, -24'sh000100, 16'd0, 16'd0, 16'd4096));
    send_pair(make_pair(-24'sh000040, -24'sh000040, 16'd0, 16'd0, 16'd4096));
    send_pair(make_pair(24'sh000100, 24'sh000000, 16'd2560, 16'd2560, 16'd0));
    send_pair(make_pair(24'sh000100, 24'sh000000, 16'd2560, 16'd2560, 16'd4096));
    send_pair(make_pair(24'sh000010, 24'sh000000, 16'd1, 16'd0, 16'd300));
    send_pair(make_pair(24'sh001000, 24'sh000000, 16'd1, 16'd0, 16'hFFFF));
    send_pair(make_pair(-24'sh000001, 24'sh000000, 16'hFFFF, 16'd0, 16'd9000));
    send_pair(make_pair(24'sh000300, -24'sh000300, 16'd1024, 16'd512, 16'd16000));
    p = make_pair(24'sh0, 24'sh0, 16'd800, 16'd800, 16'd12000);
    p.sx = 24'sh000200; p.sy = -24'sh000050; p.sz = 24'sh000007;
    send_pair(p);
    // Unused register index must leave the coefficients alone
    drain();
    write_reg(REG_UNUSED, 12'hFFF);
    send_pair(make_pair(24'sh000100, 24'sh000000, 16'd2560, 16'd2560, 16'd4096));

    // Random phases across coefficient settings and idle patterns
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_decays(12'd0, 12'd0, 12'd0);
        1: write_decays(12'hFFF, 12'hFFF, 12'hFFF);
        2: write_decays(DECAY_W'($urandom()), DECAY_W'($urandom()), DECAY_W'($urandom()));
        3: write_decays(12'd1, 12'hFFF, 12'd0);
        default: write_decays(DECAY_X_RST, DECAY_Y_RST, DECAY_Z_RST);
      endcase
      send_idle_pct = ph < 2 ? 10 : ph < 4 ? 67 : 0;
      recv_idle_pct = ph < 2 ? 67 : ph < 4 ? 10 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == 20) long_hold_req = 1;
        if (ph == 4 && i == 70) drain();
        send_pair(random_pair());
      end
    end

    // Let the pipeline empty, then give the verdict
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d coherence beats (%0d with zero speed sum) over five", checked,
             zero_speed_seen);
    $display("coefficient settings, including all-zero and all-max, with stalls both sides.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/wsc_pkg.sv
hw/rtl/wsc_if.sv
hw/rtl/wsc_dist.sv
hw/rtl/wsc_sqrt.sv
hw/rtl/wsc_div.sv
hw/rtl/wsc_exp.sv
hw/rtl/wind_spatial_coherence.sv
dv/wsc_coherence_checker.sv
dv/wind_spatial_coherence_tb.sv
